// File: sv/lers_pkg.sv
// Shared types, constants and register codes for the lane edge row scanner.
`default_nettype none

package lers_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_ROWS  = 4096;

    // Field widths.
    localparam int PIXEL_W      = 8;
    localparam int ROW_OFF_W    = 12;
    localparam int X_W          = 10;
    localparam int STRIDE_W     = 7;
    localparam int PHASE_W      = 6;
    localparam int IMG_W_W      = 11;
    localparam int GATE_DIST_W  = 10;
    localparam int OUT_FIELDS_W = ROW_OFF_W + 1 + X_W + 1 + X_W + X_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = IMG_W_W;
    localparam int STRIDE_MAX = 64;

    // Register values after reset.
    localparam int RST_ROW_STRIDE    = 10;
    localparam int RST_IMAGE_WIDTH   = 240;
    localparam int RST_GATE_ENABLE   = 0;
    localparam int RST_GATE_DISTANCE = 10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW_STRIDE    = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_GATE_ENABLE   = 2'd2,
        CFG_GATE_DISTANCE = 2'd3
    } lers_cfg_addr_t;

    typedef struct packed {
        logic [STRIDE_W-1:0]    row_stride;
        logic [IMG_W_W-1:0]     image_width;
        logic                   gate_enable;
        logic [GATE_DIST_W-1:0] gate_distance;
    } lers_cfg_t;

    typedef struct packed {
        logic [ROW_OFF_W-1:0] row_offset;
        logic                 left_found;
        logic [X_W-1:0]       left_x;
        logic                 right_found;
        logic [X_W-1:0]       right_x;
        logic [X_W-1:0]       next_center;
    } lers_result_t;

endpackage

`default_nettype wire

// File: sv/lers_core.sv
// Per-pixel row scan: counters, edge candidate search and edge/center update.
`default_nettype none

module lers_core
    import lers_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [PIXEL_W-1:0]  pixel,
    input  wire logic                frame_start,
    input  wire lers_cfg_t           cfg,
    output logic                     res_valid,
    output lers_result_t             res
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = COL_W + 1;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int GW    = (COL_W > GATE_DIST_W) ? COL_W : GATE_DIST_W;
    localparam int RST_WIDTH_EFF =
        (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam logic [COL_W-1:0] RST_CENTER = COL_W'(RST_WIDTH_EFF / 2);

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [COL_W-1:0]   center_reg;
    logic [COL_W-1:0]   left_edge_reg;
    logic [COL_W-1:0]   right_edge_reg;
    logic [COL_W-1:0]   left_cand_reg;
    logic [COL_W-1:0]   right_cand_reg;
    logic               left_hit_reg;
    logic               right_hit_reg;

    logic [EW-1:0]       width_eff;
    logic [STRIDE_W-1:0] stride_eff;

    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [PHASE_W-1:0] phase;
    logic [COL_W-1:0]   center;
    logic [COL_W-1:0]   left_cand;
    logic [COL_W-1:0]   right_cand;
    logic               left_hit;
    logic               right_hit;

    logic               scan;
    logic               zero_pix;
    logic               left_take;
    logic               right_take;
    logic               left_hit_next;
    logic               right_hit_next;
    logic [COL_W-1:0]   left_cand_next;
    logic [COL_W-1:0]   right_cand_next;
    logic               row_end;
    logic [COL_W-1:0]   left_edge_next;
    logic [COL_W-1:0]   right_edge_next;
    logic [COL_W:0]     edge_sum;
    logic [COL_W-1:0]   center_next;
    logic [STRIDE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] phase_next;
    logic [ROW_W-1:0]   row_next;

    function automatic logic gate_ok(input logic [COL_W-1:0] c, input logic [COL_W-1:0] prev,
                                     input lers_cfg_t cf);
        logic [COL_W-1:0] d;
        d = (c >= prev) ? (c - prev) : (prev - c);
        return !cf.gate_enable || (GW'(d) <= GW'(cf.gate_distance));
    endfunction

    // Out-of-range register values are clamped to the usable range.
    always_comb begin
        if (cfg.image_width == '0) begin
            width_eff = EW'(1);
        end else if (int'(cfg.image_width) > MAX_WIDTH) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = EW'(cfg.image_width);
        end
        if (cfg.row_stride == '0) begin
            stride_eff = STRIDE_W'(1);
        end else if (int'(cfg.row_stride) > STRIDE_MAX) begin
            stride_eff = STRIDE_W'(STRIDE_MAX);
        end else begin
            stride_eff = cfg.row_stride;
        end
    end

    // A frame start restarts the counters and the center before this pixel is handled.
    always_comb begin
        col        = frame_start ? '0 : col_reg;
        row        = frame_start ? '0 : row_reg;
        phase      = frame_start ? '0 : phase_reg;
        center     = frame_start ? COL_W'(width_eff >> 1) : center_reg;
        left_cand  = frame_start ? '0 : left_cand_reg;
        right_cand = frame_start ? '0 : right_cand_reg;
        left_hit   = frame_start ? 1'b0 : left_hit_reg;
        right_hit  = frame_start ? 1'b0 : right_hit_reg;
    end

    always_comb begin
        scan     = (phase == '0);
        zero_pix = (pixel == '0);
        // The left search keeps the last zero up to the center, the right one the first.
        left_take  = scan && zero_pix && (col <= center) && gate_ok(col, left_edge_reg, cfg);
        right_take = scan && zero_pix && (col >= center) && !right_hit
                     && gate_ok(col, right_edge_reg, cfg);
        left_hit_next   = left_hit || left_take;
        right_hit_next  = right_hit || right_take;
        left_cand_next  = left_take ? col : left_cand;
        right_cand_next = right_take ? col : right_cand;

        row_end = ((EW'(col) + EW'(1)) >= width_eff);

        left_edge_next  = left_hit_next ? left_cand_next : left_edge_reg;
        right_edge_next = right_hit_next ? right_cand_next : right_edge_reg;
        edge_sum        = {1'b0, left_edge_next} + {1'b0, right_edge_next};
        // The center keeps only the low bits of the average, as the result field does.
        center_next     = COL_W'(X_W'(edge_sum >> 1));

        phase_inc  = STRIDE_W'(phase) + STRIDE_W'(1);
        phase_next = (phase_inc >= stride_eff) ? '0 : PHASE_W'(phase_inc);
        row_next   = (row == ROW_W'(MAX_ROWS - 1)) ? '0 : row + ROW_W'(1);

        res_valid       = row_end && scan;
        res.row_offset  = ROW_OFF_W'(row);
        res.left_found  = left_hit_next;
        res.left_x      = X_W'(left_edge_next);
        res.right_found = right_hit_next;
        res.right_x     = X_W'(right_edge_next);
        res.next_center = X_W'(center_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= '0;
            center_reg     <= RST_CENTER;
            left_edge_reg  <= '0;
            right_edge_reg <= '0;
            left_cand_reg  <= '0;
            right_cand_reg <= '0;
            left_hit_reg   <= 1'b0;
            right_hit_reg  <= 1'b0;
        end else if (step) begin
            if (row_end) begin
                col_reg        <= '0;
                row_reg        <= row_next;
                phase_reg      <= phase_next;
                left_cand_reg  <= '0;
                right_cand_reg <= '0;
                left_hit_reg   <= 1'b0;
                right_hit_reg  <= 1'b0;
                if (scan) begin
                    left_edge_reg  <= left_edge_next;
                    right_edge_reg <= right_edge_next;
                    center_reg     <= center_next;
                end else begin
                    center_reg <= center;
                end
            end else begin
                col_reg        <= col + COL_W'(1);
                row_reg        <= row;
                phase_reg      <= phase;
                center_reg     <= center;
                left_cand_reg  <= left_cand_next;
                right_cand_reg <= right_cand_next;
                left_hit_reg   <= left_hit_next;
                right_hit_reg  <= right_hit_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/lane_edge_row_scanner.sv
// Top level: configuration registers, pixel stream input and registered result output.
// Throughput: one pixel per cycle; the input stalls only while a result waits in the
// output register and m_tready is low.
// The result of a scan row is registered and is valid in the cycle after its last pixel is accepted.
// Each pixel is handled by the compare logic in lers_core against registered edges.
// Reset (aresetn, synchronous, active low): registers return to their defaults, counters
// and edges clear, the center becomes half the default width, and no result is pending.
`default_nettype none

module lane_edge_row_scanner
    import lers_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIXEL_W-1:0]    s_tdata,    // pixel
    input  wire logic [0:0]            s_tuser,    // frame_start
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // row_offset, left_found, left_x, right_found, right_x, next_center, zero padding
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    lers_cfg_t               cfg_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    step;
    logic                    res_valid;
    lers_result_t            res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_stride    <= STRIDE_W'(RST_ROW_STRIDE);
            cfg_reg.image_width   <= IMG_W_W'(RST_IMAGE_WIDTH);
            cfg_reg.gate_enable   <= 1'(RST_GATE_ENABLE);
            cfg_reg.gate_distance <= GATE_DIST_W'(RST_GATE_DISTANCE);
        end else if (cfg_valid) begin
            unique case (lers_cfg_addr_t'(cfg_addr))
                CFG_ROW_STRIDE:    cfg_reg.row_stride    <= cfg_data[STRIDE_W-1:0];
                CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[IMG_W_W-1:0];
                CFG_GATE_ENABLE:   cfg_reg.gate_enable   <= cfg_data[0];
                CFG_GATE_DISTANCE: cfg_reg.gate_distance <= cfg_data[GATE_DIST_W-1:0];
            endcase
        end
    end

    lers_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .pixel       (s_tdata),
        .frame_start (s_tuser[0]),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // The output register is loaded whenever an accepted pixel closes a scan row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step && res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res.next_center, res.right_x, res.right_found,
                            res.left_x, res.left_found, res.row_offset};
        end
    end

endmodule

`default_nettype wire

// File: sv/lers_checker.sv
// Port-level checks for the lane edge row scanner, bound to the top level.
`default_nettype none

module lers_checker
    import lers_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int NC_LO = ROW_OFF_W + 1 + X_W + 1 + X_W;
    localparam int RX_LO = ROW_OFF_W + 1 + X_W + 1;
    localparam int LX_LO = ROW_OFF_W + 1;

    logic [X_W:0] x_sum;
    assign x_sum = {1'b0, m_tdata[LX_LO +: X_W]} + {1'b0, m_tdata[RX_LO +: X_W]};

    // A waiting result transaction holds its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input only stalls behind an untaken result.
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

    // Every new result follows an accepted pixel.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted pixel");

    // The next center is the floor average of the reported edges.
    a_center_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MAX_WIDTH > (1 << X_W)) || (m_tdata[NC_LO +: X_W] == x_sum[X_W:1]))
        else $error("next center is not the average of the edges");

    // Padding above the result fields stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0)
        else $error("nonzero padding in result");

endmodule

bind lane_edge_row_scanner lers_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_lers_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the lane edge row scanner: streams images and checks each row result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lers_pkg::*;

    // Bit positions of the result fields in m_tdata, lowest field first.
    localparam int LF_POS = ROW_OFF_W;
    localparam int LX_POS = LF_POS + 1;
    localparam int RF_POS = LX_POS + X_W;
    localparam int RX_POS = RF_POS + 1;
    localparam int NC_POS = RX_POS + X_W;

    // Pixels sent by the random frame test.
    localparam int RAND_ITEMS = 760;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copies and scan state tracked by the testbench.
    int stride_reg    = RST_ROW_STRIDE;
    int width_reg     = RST_IMAGE_WIDTH;
    int gate_on_reg   = RST_GATE_ENABLE;
    int gate_dist_reg = RST_GATE_DISTANCE;
    int col_pos = 0;
    int row_num = 0;
    int phase   = 0;
    int center  = RST_IMAGE_WIDTH / 2;
    int edge_l  = 0;
    int edge_r  = 0;
    int cand_l  = 0;
    int cand_r  = 0;
    bit hit_l   = 1'b0;
    bit hit_r   = 1'b0;

    lers_result_t pending_rows[$];
    int n_errors = 0;
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;

    lane_edge_row_scanner u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int active_width();
        if (width_reg == 0) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int active_stride();
        if (stride_reg == 0) return 1;
        if (stride_reg > STRIDE_MAX) return STRIDE_MAX;
        return stride_reg;
    endfunction

    function automatic bit near_edge(int col, int prev);
        int span;
        span = (col >= prev) ? col - prev : prev - col;
        if (gate_on_reg == 0) return 1'b1;
        return span <= gate_dist_reg;
    endfunction

    // Advances the scan state by one pixel and queues the row result at the end of a scan row.
    function automatic void scan_pixel(logic [PIXEL_W-1:0] pix, logic fs);
        int w;
        int col;
        lers_result_t r;
        w = active_width();
        if (fs) begin
            col_pos = 0;
            row_num = 0;
            phase   = 0;
            center  = w / 2;
            hit_l   = 1'b0;
            hit_r   = 1'b0;
            cand_l  = 0;
            cand_r  = 0;
        end
        col = col_pos;
        if (phase == 0 && pix == '0) begin
            if (col <= center && near_edge(col, edge_l)) begin
                cand_l = col;
                hit_l  = 1'b1;
            end
            // Only the first qualifying zero at or right of the center counts.
            if (col >= center && !hit_r && near_edge(col, edge_r)) begin
                cand_r = col;
                hit_r  = 1'b1;
            end
        end
        if (col + 1 >= w) begin
            if (phase == 0) begin
                if (hit_l) edge_l = cand_l;
                if (hit_r) edge_r = cand_r;
                center = (edge_l + edge_r) / 2;
                r.row_offset  = row_num[ROW_OFF_W-1:0];
                r.left_found  = hit_l;
                r.left_x      = edge_l[X_W-1:0];
                r.right_found = hit_r;
                r.right_x     = edge_r[X_W-1:0];
                r.next_center = center[X_W-1:0];
                pending_rows = {pending_rows, r};
            end
            hit_l   = 1'b0;
            hit_r   = 1'b0;
            cand_l  = 0;
            cand_r  = 0;
            col_pos = 0;
            phase   = phase + 1;
            if (phase >= active_stride()) phase = 0;
            row_num = (row_num + 1) % DEF_MAX_ROWS;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string msg);
        if (n_errors < 100) $display("mismatch at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, longint got_v, longint want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
    endtask

    always @(posedge aclk) begin : result_check
        lers_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                report_mismatch($sformatf("result 0x%0h with none expected", m_tdata));
            end else begin
                want = pending_rows.pop_front();
                check_field("row_offset", m_tdata[0 +: ROW_OFF_W], want.row_offset);
                check_field("left_found", m_tdata[LF_POS], want.left_found);
                check_field("left_x", m_tdata[LX_POS +: X_W], want.left_x);
                check_field("right_found", m_tdata[RF_POS], want.right_found);
                check_field("right_x", m_tdata[RX_POS +: X_W], want.right_x);
                check_field("next_center", m_tdata[NC_POS +: X_W], want.next_center);
                check_field("padding", m_tdata >> OUT_FIELDS_W, 0);
            end
        end
    end

    // Result side: random stalls while sink_idle is set, otherwise always ready.
    initial begin : sink
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold = hold - 1;
            end else begin
                m_tready <= 1'b1;
                if (sink_idle && $urandom_range(0, 99) < 30) hold = pause_len();
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with s_tvalid still high when no gap follows.
    task automatic send_pixel(logic [PIXEL_W-1:0] pix, logic fs);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        scan_pixel(pix, fs);
        @(negedge aclk);
        gap = src_idle ? pause_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // One row with zeros where the mask bit is set; other pixels cycle through fixed nonzero values.
    task automatic send_mask_row(int w, logic [63:0] mask, logic fs);
        logic [PIXEL_W-1:0] lit [3];
        lit[0] = 8'hFF;
        lit[1] = 8'h01;
        lit[2] = 8'h80;
        for (int c = 0; c < w; c++)
            send_pixel(mask[c] ? '0 : lit[c % 3], fs && c == 0);
    endtask

    // Waits until every expected result has come and the block has had time to go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(lers_cfg_addr_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ROW_STRIDE:    stride_reg    = val & ((1 << STRIDE_W) - 1);
            CFG_IMAGE_WIDTH:   width_reg     = val & ((1 << IMG_W_W) - 1);
            CFG_GATE_ENABLE:   gate_on_reg   = val & 1;
            CFG_GATE_DISTANCE: gate_dist_reg = val & ((1 << GATE_DIST_W) - 1);
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic program_scanner(int stride, int width, int gate_on, int gate_dist);
        settle();
        write_reg(CFG_ROW_STRIDE, stride);
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_GATE_ENABLE, gate_on);
        write_reg(CFG_GATE_DISTANCE, gate_dist);
        cfg_valid <= 1'b0;
    endtask

    // Counting from the reset state; the center of 120 lies beyond these short rows.
    task automatic test_without_frame_start();
        program_scanner(1, 6, 0, 10);
        send_mask_row(6, 64'b001010, 1'b0);
        send_mask_row(6, 64'b101001, 1'b0);
    endtask

    // A zero right on the center is both the left and the right edge; row stride 0 acts as 1.
    task automatic test_center_tie();
        program_scanner(0, 5, 0, 10);
        send_mask_row(5, 64'b10101, 1'b1);
        send_mask_row(5, 64'b00000, 1'b0);
    endtask

    task automatic test_gating();
        program_scanner(1, 4, 1, 0);
        send_mask_row(4, 64'b1111, 1'b1);
        program_scanner(1, 4, 1, 1023);
        send_mask_row(4, 64'b1001, 1'b0);
    endtask

    // Row stride 127 is clamped to 64 on a one-pixel-wide image.
    task automatic test_stride_limits();
        program_scanner(127, 1, 0, 10);
        for (int i = 0; i < 130; i++)
            send_pixel(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF, i == 0);
    endtask

    // Width 0 acts as 1, and 2047 acts as the largest supported width.
    task automatic test_width_limits();
        program_scanner(1, 0, 0, 10);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h00, 1'b0);
        program_scanner(1, 2047, 0, 1023);
        for (int c = 0; c < DEF_MAX_WIDTH; c++)
            send_pixel((c % 97 == 0 || c == DEF_MAX_WIDTH - 1) ? 8'h00 : 8'hA5, c == 0);
    endtask

    // Frames with two drifting lane lines plus noise, dropped lane pixels and cut-off frames.
    task automatic test_random_frames();
        int sent, w, wr, stride, gd, rows, lane_l, lane_r, noise, cut_row, cut_col, r;
        bit fresh, zero;
        logic [PIXEL_W-1:0] pix;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) wr = $urandom_range(2, 24);
            else if (r < 85) wr = $urandom_range(25, 64);
            else if (r < 92) wr = 1;
            else if (r < 97) wr = 0;
            else wr = RST_IMAGE_WIDTH;
            r = $urandom_range(0, 99);
            if (r < 60) stride = $urandom_range(1, 3);
            else if (r < 80) stride = $urandom_range(4, 10);
            else if (r < 90) stride = 0;
            else stride = $urandom_range(STRIDE_MAX, 127);
            r = $urandom_range(0, 99);
            if (r < 70) gd = $urandom_range(0, 8);
            else if (r < 90) gd = $urandom_range(9, 64);
            else gd = $urandom_range(1000, 1023);
            program_scanner(stride, wr, $urandom_range(0, 1), gd);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            w = active_width();
            repeat ($urandom_range(1, 3)) begin
                fresh   = ($urandom_range(0, 9) != 0);
                rows    = (w > 64) ? 1 : $urandom_range(1, 12);
                noise   = $urandom_range(0, 15);
                lane_l  = $urandom_range(0, w / 2);
                lane_r  = $urandom_range(w / 2, w - 1);
                cut_row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rows - 1) : rows;
                cut_col = $urandom_range(0, w - 1);
                for (int row = 0; row < rows; row++) begin
                    lane_l = lane_l + int'($urandom_range(0, 4)) - 2;
                    lane_r = lane_r + int'($urandom_range(0, 4)) - 2;
                    if (lane_l < 0) lane_l = 0;
                    if (lane_l > w - 1) lane_l = w - 1;
                    if (lane_r < 0) lane_r = 0;
                    if (lane_r > w - 1) lane_r = w - 1;
                    for (int c = 0; c < w; c++) begin
                        if (sent >= RAND_ITEMS) continue;
                        if (row > cut_row || (row == cut_row && c >= cut_col)) continue;
                        if (c == lane_l || c == lane_r) zero = ($urandom_range(0, 19) != 0);
                        else zero = ($urandom_range(0, 99) < noise);
                        if (zero) pix = '0;
                        else pix = $urandom_range(1, 255);
                        send_pixel(pix, fresh && row == 0 && c == 0);
                        sent++;
                    end
                end
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_without_frame_start();
        test_center_tie();
        test_gating();
        test_stride_limits();
        test_width_limits();
        test_random_frames();
        settle();
        repeat (6) @(posedge aclk);
        if (n_errors == 0) begin
            $display("PASS lane_edge_row_scanner");
        end else begin
            $display("FAIL lane_edge_row_scanner");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAIL lane_edge_row_scanner");
        $finish;
    end

endmodule
